// ===== sv/fhc_pkg.sv =====
package fhc_pkg;

  // Field widths
  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;

  // Direction codes carried by mode
  typedef enum logic [0:0] {
    MODE_TO_HALF   = 1'b0,
    MODE_TO_SINGLE = 1'b1
  } mode_e;

  // Single to half constants
  localparam logic [31:0] RndAdd     = 32'h0000_1000;
  localparam logic [8:0]  ExpSatMax  = 9'd143;
  localparam logic [8:0]  ExpNormMin = 9'd112;
  localparam logic [8:0]  ExpSubMin  = 9'd101;
  localparam logic [8:0]  SubShBase  = 9'd125;
  localparam logic [23:0] SubMantAdd = 24'h7F_F000;
  localparam logic [14:0] SatMag     = 15'h7FFF;

  // Half to single constants
  localparam logic [7:0]  HalfRebias = 8'd112;

  // Leading-zero count of a 10-bit half mantissa (input is nonzero)
  function automatic logic [3:0] lzc10(input logic [9:0] v);
    logic [3:0] n;
    logic       found;
    n     = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n     = 4'(9 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/fhc_to_half.sv =====
module fhc_to_half (
  input  logic [fhc_pkg::WordW-1:0] operand_i,
  output logic [fhc_pkg::WordW-1:0] result_o
);
  import fhc_pkg::*;

  logic [31:0] biased;
  logic [8:0]  exp_r;
  logic [22:0] man_r;
  logic [8:0]  sh;
  logic [23:0] sub_sum;
  logic [23:0] sub_shr;
  logic [11:0] sub_rnd;
  logic [14:0] mag;

  // Round the magnitude below the kept mantissa bits
  assign biased = {1'b0, operand_i[30:0]} + RndAdd;
  assign exp_r  = biased[31:23];
  assign man_r  = biased[22:0];

  // Subnormal path: align, then round to nearest
  assign sh      = SubShBase - exp_r;
  assign sub_sum = SubMantAdd + {1'b0, man_r};
  assign sub_shr = sub_sum >> sh[4:0];
  assign sub_rnd = 12'(({1'b0, sub_shr[10:0]} + 12'd1) >> 1);

  // Select saturate, normal, subnormal or flush to zero
  always_comb begin
    if (exp_r > ExpSatMax) begin
      mag = SatMag;
    end else if (exp_r > ExpNormMin) begin
      mag = {5'(exp_r - ExpNormMin), man_r[22:13]};
    end else if (exp_r > ExpSubMin) begin
      mag = {4'd0, sub_rnd[10:0]};
    end else begin
      mag = '0;
    end
  end

  assign result_o = {16'd0, operand_i[31], mag};

endmodule

// ===== sv/fhc_to_single.sv =====
module fhc_to_single (
  input  logic [fhc_pkg::HalfW-1:0] half_i,
  output logic [fhc_pkg::WordW-1:0] result_o
);
  import fhc_pkg::*;

  logic       sign;
  logic [4:0] exp_h;
  logic [9:0] man_h;
  logic [3:0] lz;
  logic [9:0] man_n;
  logic [7:0] exp_n;

  assign sign  = half_i[15];
  assign exp_h = half_i[14:10];
  assign man_h = half_i[9:0];

  // Normalize a subnormal: drop the leading one, rebias by its position
  assign lz    = lzc10(man_h);
  assign man_n = man_h << (lz + 4'd1);
  assign exp_n = HalfRebias - {4'd0, lz};

  always_comb begin
    if (exp_h != 5'd0) begin
      result_o = {sign, HalfRebias + {3'd0, exp_h}, man_h, 13'd0};
    end else if (man_h == 10'd0) begin
      result_o = {sign, 31'd0};
    end else begin
      result_o = {sign, exp_n, man_n, 13'd0};
    end
  end

endmodule

// ===== sv/float_half_converter_unit.sv =====
// Float/half converter. One item per cycle in each direction while the output is
// not stalled. An accepted item is held in the input register, which feeds one
// combinational converter (rounding adder, subnormal shifter and leading-zero
// count), whose output is captured in the result register; that single
// register-to-register path sets the rate. mode 0 turns a binary32 pattern into
// a binary16 pattern in the low 16 bits, with saturation to sign|0x7FFF for
// large values, infinities and NaN; mode 1 turns the low 16 bits into a finite
// binary32 pattern.
module float_half_converter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [fhc_pkg::WordW-1:0] operand_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [fhc_pkg::WordW-1:0] result_bits_o
);
  import fhc_pkg::*;

  logic              in_vld_q, in_vld_d;
  mode_e             mode_q;
  logic [WordW-1:0]  op_q;
  logic              res_vld_q, res_vld_d;
  logic [WordW-1:0]  res_q;
  logic [WordW-1:0]  half_res;
  logic [WordW-1:0]  single_res;
  logic              res_free;
  logic              in_take;
  logic              move;

  // Handshake: result register frees when empty or taken
  assign res_free   = !res_vld_q || !out_stall_i;
  assign move       = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_take || (in_vld_q && !res_free);
  assign res_vld_d = move || (res_vld_q && out_stall_i);

  // Hold valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_e'(mode_i);
      op_q   <= operand_bits_i;
    end
  end

  fhc_to_half u_to_half (
    .operand_i (op_q),
    .result_o  (half_res)
  );

  fhc_to_single u_to_single (
    .half_i   (op_q[HalfW-1:0]),
    .result_o (single_res)
  );

  // Advance the converted item into the result register
  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= (mode_q == MODE_TO_SINGLE) ? single_res : half_res;
    end
  end

  assign out_valid_o   = res_vld_q;
  assign result_bits_o = res_q;

endmodule

// ===== sv/fhc_checker.sv =====
module fhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        mode_i,
  input logic [31:0] operand_bits_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_bits_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bits_o))
    else $error("stalled result changed");

  // No input stall while the output side is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Accepted item reaches the result register if the output is not stalled while it waits in the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing");

  // Half results leave the upper half clear
  a_half_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !mode_i ##1 !out_stall_i |=> result_bits_o[31:16] == 16'd0)
    else $error("half result upper bits set");

  // Half zero widens to signed zero
  a_half_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_i && operand_bits_i[14:0] == 15'd0 ##1 !out_stall_i |=>
    result_bits_o == {$past(operand_bits_i[15], 2), 31'd0})
    else $error("half zero converted wrongly");

endmodule

bind float_half_converter_unit fhc_checker u_fhc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .mode_i         (mode_i),
  .operand_bits_i (operand_bits_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_bits_o  (result_bits_o)
);

// ===== sim/tb_float_half_converter_unit.sv =====
`timescale 1ns / 100ps

module tb_float_half_converter_unit;

  import fhc_pkg::*;

  localparam int unsigned RandItems   = 1500;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned IdlePct     = 7;
  localparam int unsigned CalmFirst   = 700;
  localparam int unsigned CalmLast    = 1000;

  // Single-to-half conversion constants
  localparam logic [31:0] RoundInc    = 32'h0000_1000;
  localparam logic [31:0] HalfSatMag  = 32'h0000_7FFF;
  localparam logic [31:0] HalfExpMask = 32'h0000_7C00;
  localparam logic [31:0] SubBias     = 32'h007F_F000;
  localparam int unsigned SatAbove    = 143;
  localparam int unsigned NormAbove   = 112;
  localparam int unsigned SubAbove    = 101;
  localparam int unsigned SubShiftTop = 125;
  // Half-to-single conversion constants
  localparam int unsigned ExpRebias   = 112;
  localparam int unsigned SubExpBase  = 90;

  typedef struct {
    mode_e       mode;
    logic [31:0] operand;
    bit          drain_first;
  } conv_item_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  mode_e                in_mode    = MODE_TO_HALF;
  logic [WordW-1:0]     in_operand = '0;
  logic                 out_stall  = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [WordW-1:0]     result_bits_o;

  conv_item_t           pending_q[$];
  logic [31:0]          expected_result_q[$];
  int unsigned          outstanding = 0;
  int unsigned          sent_cnt    = 0;
  int unsigned          cycle_cnt   = 0;
  int unsigned          err_cnt     = 0;
  logic                 calm;

  float_half_converter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .mode_i         (in_mode),
    .operand_bits_i (in_operand),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .result_bits_o  (result_bits_o)
  );

  always #2 clk_i = ~clk_i;

  // No random idling on either side while this window of items goes by
  assign calm = (sent_cnt >= CalmFirst) && (sent_cnt < CalmLast);

  // Round, rebias, denormalize or saturate a single pattern into a half pattern
  function automatic logic [31:0] single_to_half(logic [31:0] x);
    logic [31:0] biased;
    logic [31:0] ex;
    logic [31:0] man;
    logic [31:0] mag;
    biased = {1'b0, x[30:0]} + RoundInc;
    ex     = 32'(biased[31:23]);
    man    = 32'(biased[22:0]);
    if (ex > SatAbove) begin
      mag = HalfSatMag;
    end else if (ex > NormAbove) begin
      mag = (((ex - NormAbove) << 10) & HalfExpMask) | (man >> 13);
    end else if (ex > SubAbove) begin
      mag = (((SubBias + man) >> (SubShiftTop - ex)) + 32'd1) >> 1;
    end else begin
      mag = '0;
    end
    return {16'h0000, x[31], mag[14:0]};
  endfunction

  // Widen the low 16 bits into a finite single pattern
  function automatic logic [31:0] half_to_single(logic [31:0] x);
    logic [4:0]  ex;
    logic [31:0] frac;
    logic [31:0] norm;
    int unsigned msb;
    ex   = x[14:10];
    frac = 32'(x[9:0]) << 13;
    msb  = 0;
    if (ex != 5'd0) begin
      return {x[15], 8'(32'(ex) + ExpRebias), frac[22:0]};
    end
    if (frac == '0) begin
      return {x[15], 31'b0};
    end
    // Normalize the subnormal from its highest set bit
    for (int i = 0; i < 32; i++) begin
      if (frac[i]) begin
        msb = i;
      end
    end
    norm = frac << (23 - msb);
    return {x[15], 8'(SubExpBase + msb), norm[22:13], 13'b0};
  endfunction

  function automatic logic [31:0] convert_bits(mode_e mode, logic [31:0] operand);
    if (mode == MODE_TO_SINGLE) begin
      return half_to_single(operand);
    end
    return single_to_half(operand);
  endfunction

  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom;
    // Aim about half of the exponents at the subnormal, normal and saturation borders or at 0x00 and 0xFF
    case ($urandom_range(9))
      0, 1, 2: v[30:23] = 8'($urandom_range(95, 150));
      3:       v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      4:       v[30:23] = 8'($urandom_range(140, 143));
      default: ;
    endcase
    // Push the rounding increment into a carry now and then
    if ($urandom_range(3) == 0) begin
      v[22:12] = '1;
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_half();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0:       v[14:10] = 5'h1F;
      1:       v[14:10] = 5'h00;
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_item(mode_e mode, logic [31:0] operand, bit drain_first);
    conv_item_t it;
    it.mode        = mode;
    it.operand     = operand;
    it.drain_first = drain_first;
    pending_q.push_back(it);
  endtask

  // Sender: present the next item when the slot is free, idle at random
  always @(posedge clk_i) begin : drive_blk
    conv_item_t nxt;
    bit         launch;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      launch = 1'b0;
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        // Hold a marked item back until every result has returned
        launch = !pending_q[0].drain_first || (!in_valid && outstanding == 0);
      end
      if (launch) begin
        nxt = pending_q.pop_front();
        in_valid   <= 1'b1;
        in_mode    <= nxt.mode;
        in_operand <= nxt.operand;
        sent_cnt   <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: record accepted items, compare results, stall at random
  always @(posedge clk_i) begin : check_blk
    logic [31:0] want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_result_q.push_back(convert_bits(in_mode, in_operand));
      end
      if (out_valid_o && !out_stall) begin
        if (expected_result_q.size() == 0) begin
          $display("%0t: result %h with no item outstanding", $time, result_bits_o);
          err_cnt++;
        end else begin
          want = expected_result_q.pop_front();
          if (result_bits_o !== want) begin
            $display("%0t: result_bits expected %h actual %h", $time, want, result_bits_o);
            err_cnt++;
          end
        end
      end
      outstanding <= expected_result_q.size();
      out_stall   <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // Single to half: signed zeros, infinities, NaN, rounding carries,
    // normal and subnormal borders, flush to zero
    queue_item(MODE_TO_HALF, 32'h0000_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h8000_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h7F80_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'hFF80_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h7FC0_0001, 1'b0);
    queue_item(MODE_TO_HALF, 32'h7FFF_FFFF, 1'b0);
    queue_item(MODE_TO_HALF, 32'h477F_E000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h477F_F000, 1'b0);
    queue_item(MODE_TO_HALF, 32'hC7FF_F000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h3880_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'hB87F_F000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h3380_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h3300_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h32FF_F000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h3280_0000, 1'b0);
    queue_item(MODE_TO_HALF, 32'h3F80_1000, 1'b0);
    // Half to single: zeros, subnormal extremes, exponent 31, ignored upper bits
    queue_item(MODE_TO_SINGLE, 32'h0000_0000, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_8000, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_0001, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_83FF, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_0200, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_7C00, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_FFFF, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'hFFFF_3C00, 1'b0);
    queue_item(MODE_TO_SINGLE, 32'h0000_7BFF, 1'b0);

    // Random items, some held until the pipe is empty
    for (int i = 0; i < RandItems; i++) begin
      if ($urandom_range(1) == 0) begin
        queue_item(MODE_TO_HALF, rand_single(), (i % 250) == 0);
      end else begin
        queue_item(MODE_TO_SINGLE, rand_half(), (i % 250) == 0);
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all items to go in and all results to come back
    do begin
      @(negedge clk_i);
    end while (pending_q.size() > 0 || in_valid || expected_result_q.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);

    if (expected_result_q.size() > 0) begin
      $display("%0t: %0d results never arrived, next expected %h",
               $time, expected_result_q.size(), expected_result_q[0]);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
